/* rtl/core/ort_pkg.sv */
// Shared types, command codes and cell control codes for the ordered record table.
// Used by ort_cell and ordered_record_table_core; depends on nothing.
package ort_pkg;

	localparam int CAPACITY_DEF = 128;

	localparam int KEY_W = 31;
	localparam int TAG_W = 64;
	localparam int PAY_W = 64;

	// command codes
	localparam logic [2:0] CMD_INSERT_AT     = 3'd0;
	localparam logic [2:0] CMD_DELETE_AT     = 3'd1;
	localparam logic [2:0] CMD_DELETE_KEY    = 3'd2;
	localparam logic [2:0] CMD_DELETE_TAG    = 3'd3;
	localparam logic [2:0] CMD_SEARCH        = 3'd4;
	localparam logic [2:0] CMD_SORT          = 3'd5;
	localparam logic [2:0] CMD_SORTED_INSERT = 3'd6;

	// cell operations
	localparam logic [2:0] OP_HOLD = 3'd0;
	localparam logic [2:0] OP_SHDN = 3'd1;
	localparam logic [2:0] OP_SHUP = 3'd2;
	localparam logic [2:0] OP_MARK = 3'd3;
	localparam logic [2:0] OP_OET  = 3'd4;

	// scan wave modes
	localparam logic [1:0] WM_SEARCH = 2'd0;
	localparam logic [1:0] WM_TAG    = 2'd1;
	localparam logic [1:0] WM_SINS   = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [PAY_W-1:0] pay;
	} rec_t;

	typedef struct packed {
		logic [2:0] op;
		logic       phase;
		logic [1:0] mode;
	} cell_ctl_t;

	function automatic logic [7:0] fold_lc(input logic [7:0] c);
		if (c inside {[8'h41:8'h5A]}) begin
			return c + 8'd32;
		end
		return c;
	endfunction

	// zero-terminated, case-folded compare of two eight-character tags
	function automatic logic tag_match(input logic [TAG_W-1:0] a, input logic [TAG_W-1:0] b);
		logic       res;
		logic       stop;
		logic [7:0] ca;
		logic [7:0] cb;
		res  = 1'b1;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			ca = fold_lc(a[8*i +: 8]);
			cb = fold_lc(b[8*i +: 8]);
			if (!stop) begin
				if (ca != cb) begin
					res  = 1'b0;
					stop = 1'b1;
				end else if (ca == 8'd0) begin
					stop = 1'b1;
				end
			end
		end
		return res;
	endfunction

endpackage

/* rtl/core/ort_cell.sv */
// One entry of the record chain: record storage, shift and swap moves, scan wave stage.
// Depends on ort_pkg.
module ort_cell import ort_pkg::*; #(
	parameter int CW  = 8,
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [CW-1:0]    lo,
	input  logic [CW-1:0]    hi,
	input  logic [CW-1:0]    count,
	input  logic [KEY_W-1:0] key_b,
	input  logic [TAG_W-1:0] tag_b,
	input  rec_t             bus,
	input  rec_t             left_rec,
	input  logic             left_dead,
	input  rec_t             right_rec,
	input  logic             right_dead,
	input  logic             hit_in,
	input  logic [CW-1:0]    acc_in,
	output rec_t             rec,
	output logic             dead,
	output logic             hit,
	output logic [CW-1:0]    acc
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	rec_t          rec_q;
	rec_t          rec_d;
	logic          dead_q;
	logic          dead_d;
	logic          hit_q;
	logic [CW-1:0] acc_q;
	logic          occ;
	logic          m;
	logic          inc;
	logic          hit_out;

	assign occ = MY_IDX < count;

	always_comb begin
		rec_d  = rec_q;
		dead_d = dead_q;
		case (ctl.op)
			OP_SHDN: begin
				if (MY_IDX == hi) begin
					rec_d = bus;
				end else if (MY_IDX >= lo && MY_IDX < hi) begin
					rec_d = right_rec;
				end
			end
			OP_SHUP: begin
				if (MY_IDX == lo) begin
					rec_d = bus;
				end else if (MY_IDX > lo && MY_IDX <= hi) begin
					rec_d = left_rec;
				end
			end
			OP_MARK: begin
				dead_d = !occ || tag_match(rec_q.tag, tag_b);
			end
			OP_OET: begin
				if (MY_IDX[0] == ctl.phase) begin
					if (dead_q && !right_dead) begin
						rec_d  = right_rec;
						dead_d = 1'b0;
					end
				end else if (left_dead && !dead_q) begin
					rec_d  = left_rec;
					dead_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// scan wave: first hit flag and a running count, one cell per cycle
	always_comb begin
		m   = 1'b0;
		inc = 1'b0;
		case (ctl.mode)
			WM_TAG: begin
				m   = occ && tag_match(rec_q.tag, tag_b);
				inc = m;
			end
			WM_SINS: begin
				m   = occ && (rec_q.key == key_b);
				inc = occ && (rec_q.key <= key_b);
			end
			default: begin
				m   = occ && (rec_q.key == key_b);
				inc = occ && !(hit_in || m);
			end
		endcase
	end

	assign hit_out = hit_in || m;

	always_ff @(posedge clk) begin
		rec_q <= rec_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_q <= 1'b0;
			hit_q  <= 1'b0;
			acc_q  <= '0;
		end else begin
			dead_q <= dead_d;
			hit_q  <= hit_out;
			acc_q  <= acc_in + CW'(inc);
		end
	end

	assign rec  = rec_q;
	assign dead = dead_q;
	assign hit  = hit_q;
	assign acc  = acc_q;

endmodule

/* rtl/core/ordered_record_table_core.sv */
// Top level of the ordered record table: command sequencer and the chain of record cells.
// Depends on ort_pkg and ort_cell.
//
// Usage. Commands arrive on the s_ channel, one transfer per command; each command gives
// exactly one result transfer on the m_ channel. Commands run one at a time; s_tready is
// high only while the sequencer is idle. A finished result sits in the output register,
// so the next command is taken while that result still waits for m_tready.
// Records live in a row of CAPACITY cells, each holding one entry and moving it to a
// neighbor in the same cycle as every other cell. Steps per command (N = CAPACITY):
//   insert_at, delete_at             one shift of the whole row; none when rejected
//   search                           scan wave crosses the row one cell a cycle
//   delete_key                       scan wave, then one shift when the key is found
//   delete_tag                       scan wave, mark, then N odd-even compaction phases
//   sort                             the row rotates past a compare point at cell 0,
//                                    one record a cycle with a handoff step between
//                                    passes, one pass for each record but the last
//   sorted_insert                    sort if two or more records, scan wave, shift
// Reset clears the record count and the handshake state; the record storage is not
// cleared and needs no clearing pass. When the receiver stalls, hold the result and
// the sequencer waits before it reports and takes the next command.
module ordered_record_table_core import ort_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cmd[2:0], position[10:3], key[41:11], class_tag[105:42], payload[169:106]
	input  logic [175:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// ok[0], found_position[7:1], removed_count[15:8], entry_count[23:16]
	output logic [23:0]  m_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 8) ? CW : 8;
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [CW-1:0] LAST_C = CW'(CAPACITY - 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_INS  = 4'd1;
	localparam logic [3:0] ST_DEL  = 4'd2;
	localparam logic [3:0] ST_WAVE = 4'd3;
	localparam logic [3:0] ST_MARK = 4'd4;
	localparam logic [3:0] ST_OET  = 4'd5;
	localparam logic [3:0] ST_LOAD = 4'd6;
	localparam logic [3:0] ST_STEP = 4'd7;
	localparam logic [3:0] ST_HAND = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	// input fields
	logic [2:0]       in_cmd;
	logic [7:0]       in_pos;
	logic [KEY_W-1:0] in_key;
	logic [TAG_W-1:0] in_tag;
	logic [PAY_W-1:0] in_pay;

	assign in_cmd = s_tdata[2:0];
	assign in_pos = s_tdata[10:3];
	assign in_key = s_tdata[41:11];
	assign in_tag = s_tdata[105:42];
	assign in_pay = s_tdata[169:106];

	logic [3:0]       state_q;
	logic [2:0]       cmd_q;
	logic [1:0]       mode_q;
	logic [KEY_W-1:0] key_q;
	logic [TAG_W-1:0] tag_q;
	logic [PAY_W-1:0] pay_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hold_q;
	logic [CW-1:0]    pass_q;
	logic [CW-1:0]    step_q;
	rec_t             cur_q;
	logic             ok_q;
	logic [6:0]       fpos_q;
	logic [7:0]       rem_q;

	// chain wiring
	rec_t          recs  [CAPACITY];
	logic          deads [CAPACITY];
	logic          hits  [CAPACITY];
	logic [CW-1:0] accs  [CAPACITY];

	cell_ctl_t     ctl;
	logic [CW-1:0] lo_c;
	logic [CW-1:0] hi_c;
	rec_t          bus_c;
	rec_t          head;
	rec_t          new_rec;
	logic [CW-1:0] n1;
	logic [CW-1:0] n2;
	logic          cmp_on;
	logic          take_e;
	logic          hit_last;
	logic [CW-1:0] acc_last;
	logic [PW-1:0] acc_x;
	logic [PW-1:0] cnt_x;
	logic [PW-1:0] pos_x;
	logic          accept;

	assign head     = recs[0];
	assign hit_last = hits[CAPACITY-1];
	assign acc_last = accs[CAPACITY-1];
	assign acc_x    = PW'(acc_last);
	assign cnt_x    = PW'(count_q);
	assign pos_x    = PW'(in_pos);
	assign n1       = count_q - CW'(1);
	assign n2       = count_q - CW'(2);
	assign new_rec  = '{key: key_q, tag: tag_q, pay: pay_q};
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// compare only against the unsorted tail of the current pass
	assign cmp_on = ({1'b0, step_q} + {1'b0, pass_q}) < {1'b0, n1};
	assign take_e = cmp_on && (cur_q.key > head.key);

	always_comb begin
		ctl.op    = OP_HOLD;
		ctl.phase = cnt_q[0];
		ctl.mode  = mode_q;
		lo_c      = '0;
		hi_c      = '0;
		bus_c     = cur_q;
		case (state_q)
			ST_INS: begin
				ctl.op = OP_SHUP;
				lo_c   = lo_q;
				hi_c   = count_q;
				bus_c  = new_rec;
			end
			ST_DEL: begin
				ctl.op = OP_SHDN;
				lo_c   = lo_q;
				hi_c   = n1;
			end
			ST_MARK: ctl.op = OP_MARK;
			ST_OET:  ctl.op = OP_OET;
			ST_LOAD: begin
				ctl.op = OP_SHDN;
				hi_c   = n1;
			end
			ST_STEP: begin
				ctl.op = OP_SHDN;
				hi_c   = n2;
				bus_c  = take_e ? cur_q : head;
			end
			ST_HAND: begin
				ctl.op = OP_SHDN;
				hi_c   = n2;
			end
			ST_FIN: begin
				ctl.op = OP_SHDN;
				lo_c   = n1;
				hi_c   = n1;
			end
			default: ;
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		rec_t          l_rec;
		logic          l_dead;
		rec_t          r_rec;
		logic          r_dead;
		logic          h_in;
		logic [CW-1:0] a_in;

		if (g == 0) begin : g_first
			assign l_rec  = recs[g];
			assign l_dead = 1'b0;
			assign h_in   = 1'b0;
			assign a_in   = '0;
		end else begin : g_mid
			assign l_rec  = recs[g-1];
			assign l_dead = deads[g-1];
			assign h_in   = hits[g-1];
			assign a_in   = accs[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign r_rec  = recs[g];
			assign r_dead = 1'b1;
		end else begin : g_inner
			assign r_rec  = recs[g+1];
			assign r_dead = deads[g+1];
		end

		ort_cell #(
			.CW  (CW),
			.IDX (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.lo         (lo_c),
			.hi         (hi_c),
			.count      (count_q),
			.key_b      (key_q),
			.tag_b      (tag_q),
			.bus        (bus_c),
			.left_rec   (l_rec),
			.left_dead  (l_dead),
			.right_rec  (r_rec),
			.right_dead (r_dead),
			.hit_in     (h_in),
			.acc_in     (a_in),
			.rec        (recs[g]),
			.dead       (deads[g]),
			.hit        (hits[g]),
			.acc        (accs[g])
		);
	end

	// command fields and the running sort record: no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_cmd;
			key_q <= in_key;
			tag_q <= in_tag;
			pay_q <= in_pay;
		end
		case (state_q)
			ST_LOAD: cur_q <= head;
			ST_STEP: if (take_e) cur_q <= head;
			ST_HAND: cur_q <= head;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= WM_SEARCH;
			count_q  <= '0;
			cnt_q    <= '0;
			lo_q     <= '0;
			hold_q   <= '0;
			pass_q   <= '0;
			step_q   <= '0;
			ok_q     <= 1'b0;
			fpos_q   <= '0;
			rem_q    <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			// drop the result once taken; the report state handles its own cycle
			if (m_tvalid && m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ok_q   <= 1'b0;
						fpos_q <= '0;
						rem_q  <= '0;
						cnt_q  <= '0;
						pass_q <= '0;
						step_q <= '0;
						case (in_cmd)
							CMD_INSERT_AT: begin
								if (count_q < CAP_C && pos_x <= cnt_x) begin
									lo_q    <= CW'(in_pos);
									ok_q    <= 1'b1;
									state_q <= ST_INS;
								end else begin
									state_q <= ST_DONE;
								end
							end
							CMD_DELETE_AT: begin
								if (pos_x < cnt_x) begin
									lo_q    <= CW'(in_pos);
									ok_q    <= 1'b1;
									state_q <= ST_DEL;
								end else begin
									state_q <= ST_DONE;
								end
							end
							CMD_DELETE_KEY, CMD_SEARCH: begin
								mode_q  <= WM_SEARCH;
								state_q <= ST_WAVE;
							end
							CMD_DELETE_TAG: begin
								mode_q  <= WM_TAG;
								state_q <= ST_WAVE;
							end
							CMD_SORT: begin
								if (count_q >= CW'(2)) begin
									state_q <= ST_LOAD;
								end else begin
									ok_q    <= (count_q != '0);
									state_q <= ST_DONE;
								end
							end
							CMD_SORTED_INSERT: begin
								mode_q <= WM_SINS;
								if (count_q >= CW'(2)) begin
									state_q <= ST_LOAD;
								end else if (count_q < CAP_C) begin
									state_q <= ST_WAVE;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_INS: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_DONE;
				end
				ST_DEL: begin
					count_q <= n1;
					state_q <= ST_DONE;
				end
				ST_WAVE: begin
					if (cnt_q == CAP_C) begin
						cnt_q <= '0;
						case (cmd_q)
							CMD_DELETE_KEY: begin
								if (hit_last) begin
									lo_q    <= acc_last;
									ok_q    <= 1'b1;
									state_q <= ST_DEL;
								end else begin
									state_q <= ST_DONE;
								end
							end
							CMD_DELETE_TAG: begin
								hold_q  <= acc_last;
								rem_q   <= acc_x[7:0];
								state_q <= ST_MARK;
							end
							CMD_SORTED_INSERT: begin
								if (!hit_last) begin
									lo_q    <= acc_last;
									ok_q    <= 1'b1;
									state_q <= ST_INS;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: begin
								ok_q    <= hit_last;
								fpos_q  <= hit_last ? acc_x[6:0] : 7'd0;
								state_q <= ST_DONE;
							end
						endcase
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_MARK: begin
					cnt_q   <= '0;
					state_q <= ST_OET;
				end
				ST_OET: begin
					if (cnt_q == LAST_C) begin
						count_q <= count_q - hold_q;
						ok_q    <= (hold_q != '0);
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_LOAD: begin
					step_q  <= '0;
					pass_q  <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (step_q == n2) begin
						step_q  <= '0;
						state_q <= ST_HAND;
					end else begin
						step_q <= step_q + CW'(1);
					end
				end
				ST_HAND: begin
					if (pass_q == n2) begin
						state_q <= ST_FIN;
					end else begin
						pass_q  <= pass_q + CW'(1);
						state_q <= ST_STEP;
					end
				end
				ST_FIN: begin
					cnt_q <= '0;
					if (cmd_q == CMD_SORTED_INSERT) begin
						state_q <= (count_q < CAP_C) ? ST_WAVE : ST_DONE;
					end else begin
						ok_q    <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the previous result has left the output register
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {cnt_x[7:0], rem_q, fpos_q, ok_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("record count above capacity");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not add exactly one record");

	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[15:8] != 8'd0) |-> m_tdata[0])
		else $error("records removed but ok low");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[7:1] != 7'd0) |-> m_tdata[0])
		else $error("found position without ok");

endmodule
